// ===== hw/rtl/mi4_pkg.sv =====
package mi4_pkg;

  localparam int unsigned WIDE = 64;

  typedef logic signed [WIDE-1:0] wide_t;

  localparam logic signed [WIDE:0] SUM_MAX = {2'b00, {(WIDE-1){1'b1}}};
  localparam logic signed [WIDE:0] SUM_MIN = -SUM_MAX;

  // Multiply phase: which step of the sequence the product feeds.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_DET    = 2'd2
  } mphase_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_FA   = 11'b00000000010,
    S_FB   = 11'b00000000100,
    S_FC   = 11'b00000001000,
    S_MUL  = 11'b00000010000,
    S_MFIN = 11'b00000100000,
    S_DA   = 11'b00001000000,
    S_DB   = 11'b00010000000,
    S_VA   = 11'b00100000000,
    S_VB   = 11'b01000000000,
    S_DIV  = 11'b10000000000
  } state_t;

  // Column order of the six terms of a 3x3 determinant, packed {c0, c1, c2}.
  function automatic logic [5:0] perm_cols(input logic [2:0] p);
    logic [5:0] v;
    case (p)
      3'd0:    v = {2'd0, 2'd1, 2'd2};
      3'd1:    v = {2'd0, 2'd2, 2'd1};
      3'd2:    v = {2'd1, 2'd0, 2'd2};
      3'd3:    v = {2'd1, 2'd2, 2'd0};
      3'd4:    v = {2'd2, 2'd0, 2'd1};
      default: v = {2'd2, 2'd1, 2'd0};
    endcase
    return v;
  endfunction

  function automatic logic perm_neg(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  // Matrix position of factor f of term p of the minor for adjugate entry k.
  // The minor drops row c and column r of the matrix, where k = 4r + c.
  function automatic logic [3:0] fidx(input logic [3:0] k, input logic [2:0] p,
                                      input logic [1:0] f);
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] row;
    logic [1:0] pc;
    logic [1:0] col;
    logic [5:0] pt;
    r   = k[3:2];
    c   = k[1:0];
    row = (f < c) ? f : f + 2'd1;
    pt  = perm_cols(p);
    case (f)
      2'd0:    pc = pt[5:4];
      2'd1:    pc = pt[3:2];
      default: pc = pt[1:0];
    endcase
    col = (pc < r) ? pc : pc + 2'd1;
    return {row, col};
  endfunction

  function automatic wide_t sat_add(input wide_t a, input wide_t b);
    logic signed [WIDE:0] s;
    wide_t r;
    s = {a[WIDE-1], a} + {b[WIDE-1], b};
    if (s > SUM_MAX) r = SUM_MAX[WIDE-1:0];
    else if (s < SUM_MIN) r = SUM_MIN[WIDE-1:0];
    else r = s[WIDE-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/matrix4_inverse_cofactor.sv =====
// 4x4 matrix inverse by cofactors, signed fixed point, one shared 32x32 multiplier
// and one bit-serial divider. Elements load at one word per cycle while busy is low.
// After the last element the sequencer sums the 96 triple product terms of the sixteen minors,
// then the four determinant terms, and divides each adjugate entry by the determinant.
// A singular matrix gives sixteen zero results instead. Results cannot be stalled.
// Reset (rst, synchronous) returns the sequencer to idle and clears the determinant.
module matrix4_inverse_cofactor #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   elem_index,
  input  logic signed [DATA_WIDTH-1:0] elem_value,
  input  logic                         load_last,
  output logic                         strobe,
  output logic [3:0]                   out_index,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         singular,
  output logic                         out_last
);
  import mi4_pkg::*;

  localparam int EXT = WIDE - DATA_WIDTH;

  state_t  state;
  mphase_t mphase;

  // Counters: k walks adjugate entries, determinant terms and results; p walks
  // the six terms of one minor.
  logic [3:0] k;
  logic [2:0] p;

  // Matrix and adjugate stores with registered read ports.
  logic signed [DATA_WIDTH-1:0] mat_mem [16];
  wide_t                        cof_mem [16];
  logic signed [DATA_WIDTH-1:0] mat_rdata;
  wide_t                        cof_rdata;
  logic [3:0]                   mat_raddr;
  logic [3:0]                   cof_raddr;
  logic                         mat_we;
  logic                         cof_we;
  wide_t                        cof_wdata;

  // Shared multiplier: operands, partial product and 128-bit accumulator.
  wide_t          opa;
  wide_t          opb;
  logic [2:0]     mcnt;
  logic [63:0]    pp;
  logic [1:0]     pshift;
  logic [127:0]   macc;
  logic [63:0]    ma;
  logic [63:0]    mb;
  logic [31:0]    ma_half;
  logic [31:0]    mb_half;
  logic [127:0]   pp_shifted;
  logic           mag_over;
  logic [62:0]    mag;
  wide_t          prod;
  wide_t          term;
  wide_t          sum_new;

  // Running sum of one minor and the determinant.
  wide_t sum;
  wide_t det;

  // Bit-serial divider.
  logic [127:0]            num;
  logic [63:0]             rem;
  logic [63:0]             dvs;
  logic [6:0]              bitpos;
  logic [DATA_WIDTH-1:0]   quo;
  logic                    over;
  logic                    qneg;
  logic [63:0]             rem_sh;
  logic                    take;
  logic [DATA_WIDTH-1:0]   quo_next;
  logic                    over_next;
  logic [DATA_WIDTH-1:0]   limit;
  logic [DATA_WIDTH-1:0]   quo_sat;
  logic [63:0]             cof_mag;
  logic [63:0]             det_mag;

  assign busy   = (state != S_IDLE);
  assign mat_we = start && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[elem_index] <= elem_value;
    end
    mat_rdata <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (cof_we) begin
      cof_mem[k] <= cof_wdata;
    end
    cof_rdata <= cof_mem[cof_raddr];
  end

  always_comb begin
    unique case (state)
      S_FA:    mat_raddr = fidx(k, p, 2'd0);
      S_FB:    mat_raddr = fidx(k, p, 2'd1);
      S_MFIN:  mat_raddr = fidx(k, p, 2'd2);
      S_DA:    mat_raddr = {2'b00, k[1:0]};
      default: mat_raddr = 4'd0;
    endcase
    cof_raddr = (state == S_DA) ? {k[1:0], 2'b00} : k;
  end

  // Multiplier datapath. Magnitudes are split into 32-bit halves; step mcnt
  // takes half mcnt[1] of a against half mcnt[0] of b.
  assign ma      = opa[WIDE-1] ? 64'(-opa) : 64'(opa);
  assign mb      = opb[WIDE-1] ? 64'(-opb) : 64'(opb);
  assign ma_half = mcnt[1] ? ma[63:32] : ma[31:0];
  assign mb_half = mcnt[0] ? mb[63:32] : mb[31:0];

  always_comb begin
    case (pshift)
      2'd0:    pp_shifted = {64'b0, pp};
      2'd1:    pp_shifted = {32'b0, pp, 32'b0};
      default: pp_shifted = {pp, 64'b0};
    endcase
  end

  // Drop the fraction bits, saturate the magnitude and restore the sign.
  assign mag_over = |macc[127:63+FRAC_BITS];
  assign mag      = mag_over ? {63{1'b1}} : macc[62+FRAC_BITS:FRAC_BITS];
  assign prod     = (opa[WIDE-1] ^ opb[WIDE-1]) ? -$signed({1'b0, mag})
                                                 : $signed({1'b0, mag});
  assign term     = perm_neg(p) ? -prod : prod;
  assign sum_new  = sat_add(sum, term);

  always_comb begin
    cof_we    = (state == S_MFIN) && (mphase == PH_SECOND) && (p == 3'd5);
    cof_wdata = (k[2] ^ k[0]) ? -sum_new : sum_new;
  end

  // Restoring division step on the quotient magnitude.
  assign cof_mag   = cof_rdata[WIDE-1] ? 64'(-cof_rdata) : 64'(cof_rdata);
  assign det_mag   = det[WIDE-1] ? 64'(-det) : 64'(det);
  assign rem_sh    = {rem[62:0], num[127]};
  assign take      = rem[63] || (rem_sh >= dvs);
  assign quo_next  = (take && (32'(bitpos) < DATA_WIDTH))
                     ? (quo | (DATA_WIDTH'(1) << bitpos)) : quo;
  assign over_next = over || (take && (32'(bitpos) >= DATA_WIDTH));
  assign limit     = qneg ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                          : {1'b0, {(DATA_WIDTH-1){1'b1}}};
  assign quo_sat   = (over_next || (quo_next > limit)) ? limit : quo_next;

  // The strobe marks the cycle in which a result word sits on the outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ((state == S_VB) && (det == '0)) || ((state == S_DIV) && (bitpos == 7'd0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mphase <= PH_FIRST;
      k      <= 4'd0;
      p      <= 3'd0;
      mcnt   <= 3'd0;
      det    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && load_last) begin
            k     <= 4'd0;
            p     <= 3'd0;
            sum   <= '0;
            state <= S_FA;
          end
        end
        S_FA: begin
          state <= S_FB;
        end
        S_FB: begin
          opa    <= {{EXT{mat_rdata[DATA_WIDTH-1]}}, mat_rdata};
          mphase <= PH_FIRST;
          state  <= S_FC;
        end
        S_FC: begin
          opb   <= {{EXT{mat_rdata[DATA_WIDTH-1]}}, mat_rdata};
          mcnt  <= 3'd0;
          macc  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mcnt != 3'd4) begin
            pp     <= ma_half * mb_half;
            pshift <= {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
          end
          if (mcnt != 3'd0) begin
            macc <= macc + pp_shifted;
          end
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) begin
            state <= S_MFIN;
          end
        end
        S_MFIN: begin
          unique case (mphase)
            PH_FIRST: begin
              // The read of the third factor was issued this cycle.
              opa    <= prod;
              mphase <= PH_SECOND;
              state  <= S_FC;
            end
            PH_SECOND: begin
              if (p == 3'd5) begin
                sum <= '0;
                p   <= 3'd0;
                if (k == 4'd15) begin
                  k     <= 4'd0;
                  det   <= '0;
                  state <= S_DA;
                end else begin
                  k     <= k + 4'd1;
                  state <= S_FA;
                end
              end else begin
                sum   <= sum_new;
                p     <= p + 3'd1;
                state <= S_FA;
              end
            end
            default: begin
              det <= sat_add(det, prod);
              if (k[1:0] == 2'd3) begin
                k     <= 4'd0;
                state <= S_VA;
              end else begin
                k     <= k + 4'd1;
                state <= S_DA;
              end
            end
          endcase
        end
        S_DA: begin
          state <= S_DB;
        end
        S_DB: begin
          opa    <= {{EXT{mat_rdata[DATA_WIDTH-1]}}, mat_rdata};
          opb    <= cof_rdata;
          mphase <= PH_DET;
          mcnt   <= 3'd0;
          macc   <= '0;
          state  <= S_MUL;
        end
        S_VA: begin
          state <= S_VB;
        end
        S_VB: begin
          if (det == '0) begin
            out_index <= k;
            out_value <= '0;
            singular  <= 1'b1;
            out_last  <= (k == 4'd15);
            k         <= k + 4'd1;
            state     <= (k == 4'd15) ? S_IDLE : S_VA;
          end else begin
            num    <= {64'b0, cof_mag} << FRAC_BITS;
            rem    <= '0;
            dvs    <= det_mag;
            bitpos <= 7'd127;
            quo    <= '0;
            over   <= 1'b0;
            qneg   <= cof_rdata[WIDE-1] ^ det[WIDE-1];
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= take ? (rem_sh - dvs) : rem_sh;
          num    <= {num[126:0], 1'b0};
          quo    <= quo_next;
          over   <= over_next;
          bitpos <= bitpos - 7'd1;
          if (bitpos == 7'd0) begin
            out_index <= k;
            out_value <= qneg ? -quo_sat : quo_sat;
            singular  <= 1'b0;
            out_last  <= (k == 4'd15);
            k         <= k + 4'd1;
            state     <= (k == 4'd15) ? S_IDLE : S_VA;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  import mi4_pkg::*;

  localparam int FRAC = 16;
  localparam longint QMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        last;
    logic        drain;
  } word_t;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        sing;
    logic        last;
  } inv_elem_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  elem_index;
  logic signed [31:0] elem_value;
  logic        load_last;
  logic        strobe;
  logic [3:0]  out_index;
  logic signed [31:0] out_value;
  logic        singular;
  logic        out_last;

  word_t     pending_words[$];
  inv_elem_t inverse_due[$];
  longint    mat[16];
  int        words_sent;
  bit        failed;

  matrix4_inverse_cofactor dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .elem_index(elem_index), .elem_value(elem_value), .load_last(load_last),
    .strobe(strobe), .out_index(out_index), .out_value(out_value),
    .singular(singular), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Fixed-point product: exact magnitude product, truncated, saturated.
  function automatic longint mul_q(longint x, longint y);
    logic [127:0] ax;
    logic [127:0] ay;
    logic [127:0] p;
    longint m;
    ax = (x < 0) ? 128'(-x) : 128'(x);
    ay = (y < 0) ? 128'(-y) : 128'(y);
    p = (ax * ay) >> FRAC;
    m = (p > 128'(QMAX)) ? QMAX : longint'(p[63:0]);
    return ((x < 0) != (y < 0)) ? -m : m;
  endfunction

  function automatic longint add_q(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > QMAX) return QMAX;
    if (s < -QMAX) return -QMAX;
    return longint'(s[63:0]);
  endfunction

  // Signed adjugate entry (r,c): the minor that drops row c and column r.
  function automatic longint adjugate_entry(int r, int c);
    int rows[3];
    int cols[3];
    int pc[6][3];
    bit pneg[6];
    int n;
    longint acc;
    longint t;
    pc = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2}, '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};
    pneg = '{0, 1, 1, 0, 0, 1};
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin
      rows[n] = k;
      n++;
    end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin
      cols[n] = k;
      n++;
    end
    acc = 0;
    for (int p = 0; p < 6; p++) begin
      t = mul_q(mul_q(mat[rows[0]*4 + cols[pc[p][0]]], mat[rows[1]*4 + cols[pc[p][1]]]),
                mat[rows[2]*4 + cols[pc[p][2]]]);
      if (pneg[p]) t = -t;
      acc = add_q(acc, t);
    end
    return ((r + c) % 2 == 1) ? -acc : acc;
  endfunction

  // Quotient adj/det in fixed point, saturated to the signed 32-bit range.
  function automatic logic [31:0] div_q(longint num, longint den);
    logic [127:0] nm;
    logic [127:0] dm;
    logic [127:0] q;
    logic [127:0] lim;
    bit neg;
    nm = ((num < 0) ? 128'(-num) : 128'(num)) << FRAC;
    dm = (den < 0) ? 128'(-den) : 128'(den);
    neg = (num < 0) != (den < 0);
    q = nm / dm;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // Store the word; on the last word queue the sixteen inverse elements.
  task automatic predict_inverse(word_t w);
    longint cof[16];
    longint det;
    inv_elem_t e;
    mat[w.idx] = longint'($signed(w.val));
    if (w.last) begin
      for (int k = 0; k < 16; k++) cof[k] = adjugate_entry(k / 4, k % 4);
      det = 0;
      for (int k = 0; k < 4; k++) det = add_q(det, mul_q(mat[k], cof[k*4]));
      for (int k = 0; k < 16; k++) begin
        e.idx  = 4'(k);
        e.sing = (det == 0);
        e.val  = e.sing ? 32'd0 : div_q(cof[k], det);
        e.last = (k == 15);
        inverse_due.push_back(e);
      end
    end
  endtask

  // Driver: the word at the head of the queue is presented until accepted.
  always @(posedge clk) begin
    word_t w;
    bit go;
    if (rst) begin
      start      <= 1'b0;
      elem_index <= '0;
      elem_value <= '0;
      load_last  <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_inverse(pending_words.pop_front());
        words_sent++;
      end
      go = pending_words.size() > 0;
      if (go) begin
        w = pending_words[0];
        if (w.drain && inverse_due.size() > 0) go = 0;
        // No idling in the quiet stretch between words 120 and 220.
        if (!(words_sent >= 120 && words_sent < 220) && $urandom_range(99) < 7) go = 0;
      end
      start <= go;
      if (go) begin
        elem_index <= w.idx;
        elem_value <= w.val;
        load_last  <= w.last;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected inverse element.
  always @(posedge clk) begin
    inv_elem_t e;
    if (!rst && strobe) begin
      if (inverse_due.size() == 0) begin
        $error("unexpected result word at index %0d", out_index);
        failed = 1;
      end else begin
        e = inverse_due.pop_front();
        if (out_index !== e.idx) begin
          $error("out_index: expected %0d, got %0d", e.idx, out_index);
          failed = 1;
        end
        if (out_value !== e.val) begin
          $error("out_value: expected %h, got %h", e.val, out_value);
          failed = 1;
        end
        if (singular !== e.sing) begin
          $error("singular: expected %0b, got %0b", e.sing, singular);
          failed = 1;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %0b, got %0b", e.last, out_last);
          failed = 1;
        end
      end
    end
  end

  task automatic push_word(int idx, logic [31:0] val, bit last, bit drain = 0);
    word_t w;
    w.idx = 4'(idx);
    w.val = val;
    w.last = last;
    w.drain = drain;
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] rand_value(int kind);
    case (kind)
      0: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
      1: return $urandom();
      default: return (($urandom_range(3) == 0) ? 32'd0 : ONE)
                      + 32'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // One full matrix, row-major; a zero row makes it exactly singular.
  task automatic push_matrix(int kind, bit drain);
    int zrow;
    zrow = ($urandom_range(4) == 0) ? $urandom_range(3) : -1;
    for (int k = 0; k < 16; k++) begin
      push_word(k, (k / 4 == zrow) ? 32'd0
                   : (kind == 2 ? ((k % 5 == 0) ? ONE : rand_value(0) >>> 4)
                                : rand_value(kind)),
                k == 15, drain && k == 0);
    end
  endtask

  initial begin
    int kind;
    int n;
    rst = 1'b1;

    // Directed: identity, then extreme corner values, then an update of element 0, then a zeroed row.
    // The sender waits for every pending result before the third update.
    for (int k = 0; k < 16; k++) push_word(k, (k % 5 == 0) ? ONE : 32'd0, k == 15);
    push_word(5, 32'h7fff_ffff, 0);
    push_word(10, 32'h8000_0000, 1);
    push_word(0, 32'hffff_ffff, 0, 1);
    push_word(0, ONE, 1);
    push_word(12, 32'd0, 0);
    push_word(13, 32'd0, 0);
    push_word(14, 32'd0, 0);
    push_word(15, 32'd0, 1);

    // Random: mostly whole matrices, some sparse updates with repeats.
    while (pending_words.size() < 350) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        push_matrix(kind % 3, pending_words.size() > 200 && pending_words.size() < 220);
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          push_word($urandom_range(15), rand_value($urandom_range(2)), i == n - 1);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !start);
    wait (inverse_due.size() == 0);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("** matrix4_inverse_cofactor: PASSED **");
    end else begin
      $display("** matrix4_inverse_cofactor: FAILED **");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("** matrix4_inverse_cofactor: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mi4_pkg.sv
hw/rtl/matrix4_inverse_cofactor.sv
verif/tb.sv
